/* rtl/tanimoto_similarity_unit_macros.svh */
// ----------------------------------------------------------------------------
// Tanimoto similarity unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TANIMOTO_SIMILARITY_UNIT_MACROS_SVH
`define TANIMOTO_SIMILARITY_UNIT_MACROS_SVH

// Same-cycle implication.
`define TSU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsu: same-cycle check failed");

// Next-cycle implication.
`define TSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsu: next-cycle check failed");

`endif

/* rtl/tsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanimoto similarity unit package
// Shared constants, the per-vector tail information and width helpers.
// ----------------------------------------------------------------------------
package tsu_pkg;

    localparam int DEF_MAX_LENGTH = 1024;
    localparam int DEF_VALUE_BITS = 16;
    localparam int MAX_SUM_W      = 64;
    localparam int SIM_W          = 16;
    localparam int ELEM_COUNT_W   = 11;
    localparam int FRAC_STEPS     = 15;
    localparam int Q_DEPTH        = 2;

    localparam logic [SIM_W-1:0] ONE_Q14 = SIM_W'(16384);

    typedef struct packed {
        logic                    overflow;
        logic [ELEM_COUNT_W-1:0] count;
    } t_tail_info;

    function automatic int sum_width(input int value_bits, input int max_length);
        int w;
        w = 2 * value_bits + $clog2(max_length + 1) + 2;
        return (w > MAX_SUM_W) ? MAX_SUM_W : w;
    endfunction

endpackage

/* rtl/tanimoto_similarity_unit.sv */
// Throughput: one item per cycle while o_stall is low; o_stall holds the input when the
// last item of a vector pair meets a full queue. The back-end divider works on one vector
// pair at a time and skips the division when the denominator is zero or the ratio saturates,
// and a two-entry queue absorbs short vectors. Reset is synchronous, active low, and clears all control state.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanimoto similarity unit
// Streams element pairs of two vectors and returns their Tanimoto coefficient.
// ----------------------------------------------------------------------------
module tanimoto_similarity_unit import tsu_pkg::*; #(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VALUE_BITS-1:0] i_first_value,
    input  logic signed [VALUE_BITS-1:0] i_second_value,
    input  logic                         i_last_element,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SIM_W-1:0]      o_similarity,
    output logic                         o_zero_denominator,
    output logic                         o_length_overflow,
    output logic [ELEM_COUNT_W-1:0]      o_element_count
);

    localparam int SUM_W  = sum_width(VALUE_BITS, MAX_LENGTH);
    localparam int INFO_W = $bits(t_tail_info);
    localparam int QD_W   = 3 * SUM_W + INFO_W;

    logic              w_push;
    logic              w_full;
    logic [SUM_W-1:0]  w_push_xy;
    logic [SUM_W-1:0]  w_push_xx;
    logic [SUM_W-1:0]  w_push_yy;
    t_tail_info        w_push_info;
    logic [QD_W-1:0]   w_push_data;
    logic              w_pop_valid;
    logic              w_pop;
    logic [QD_W-1:0]   w_pop_data;

    tsu_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_last_element (i_last_element),
        .o_push         (w_push),
        .i_full         (w_full),
        .o_push_xy      (w_push_xy),
        .o_push_xx      (w_push_xx),
        .o_push_yy      (w_push_yy),
        .o_push_info    (w_push_info)
    );

    assign w_push_data = {w_push_xy, w_push_xx, w_push_yy, w_push_info};

    tsu_queue #(
        .DATA_W (QD_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_pop_valid (w_pop_valid),
        .o_pop_data  (w_pop_data),
        .i_pop       (w_pop)
    );

    tsu_divider #(
        .SUM_W (SUM_W)
    ) u_divider (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pop_valid        (w_pop_valid),
        .o_pop              (w_pop),
        .i_xy               (w_pop_data[QD_W-1 -: SUM_W]),
        .i_xx               (w_pop_data[QD_W-SUM_W-1 -: SUM_W]),
        .i_yy               (w_pop_data[INFO_W+SUM_W-1 -: SUM_W]),
        .i_info             (t_tail_info'(w_pop_data[INFO_W-1:0])),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_similarity       (o_similarity),
        .o_zero_denominator (o_zero_denominator),
        .o_length_overflow  (o_length_overflow),
        .o_element_count    (o_element_count)
    );

endmodule

/* rtl/tsu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanimoto similarity front end
// Accepts element pairs, forms the three products and accumulates the sums.
// ----------------------------------------------------------------------------
module tsu_front import tsu_pkg::*; #(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [VALUE_BITS-1:0]   i_first_value,
    input  logic signed [VALUE_BITS-1:0]   i_second_value,
    input  logic                           i_last_element,
    output logic                           o_push,
    input  logic                           i_full,
    output logic [sum_width(VALUE_BITS, MAX_LENGTH)-1:0] o_push_xy,
    output logic [sum_width(VALUE_BITS, MAX_LENGTH)-1:0] o_push_xx,
    output logic [sum_width(VALUE_BITS, MAX_LENGTH)-1:0] o_push_yy,
    output t_tail_info                     o_push_info
);

    localparam int SUM_W  = sum_width(VALUE_BITS, MAX_LENGTH);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int PROD_W = 2 * VALUE_BITS;

    logic                         r_in_valid;
    logic                         r_in_last;
    logic signed [VALUE_BITS-1:0] r_in_x;
    logic signed [VALUE_BITS-1:0] r_in_y;
    logic                         r_p_valid;
    logic                         r_p_last;
    logic signed [PROD_W-1:0]     r_p_xx;
    logic signed [PROD_W-1:0]     r_p_yy;
    logic signed [PROD_W-1:0]     r_p_xy;
    logic signed [SUM_W-1:0]      r_sum_xx;
    logic signed [SUM_W-1:0]      r_sum_yy;
    logic signed [SUM_W-1:0]      r_sum_xy;
    logic [CNT_W-1:0]             r_count;
    logic                         r_ovf;

    logic signed [SUM_W-1:0]      n_sum_xx;
    logic signed [SUM_W-1:0]      n_sum_yy;
    logic signed [SUM_W-1:0]      n_sum_xy;
    logic [CNT_W-1:0]             n_count;
    logic                         n_ovf;
    logic                         w_hold;
    logic                         w_take;

    assign w_hold  = r_p_valid & r_p_last & i_full;
    assign o_stall = w_hold;
    assign w_take  = r_count < CNT_W'(MAX_LENGTH);

    always_comb begin
        n_sum_xx = r_sum_xx;
        n_sum_yy = r_sum_yy;
        n_sum_xy = r_sum_xy;
        n_count  = r_count;
        n_ovf    = r_ovf | ~w_take;
        if (w_take) begin
            n_sum_xx = r_sum_xx + SUM_W'(r_p_xx);
            n_sum_yy = r_sum_yy + SUM_W'(r_p_yy);
            n_sum_xy = r_sum_xy + SUM_W'(r_p_xy);
            n_count  = r_count + CNT_W'(1);
        end
    end

    assign o_push            = r_p_valid & r_p_last & ~i_full;
    assign o_push_xx         = n_sum_xx;
    assign o_push_yy         = n_sum_yy;
    assign o_push_xy         = n_sum_xy;
    assign o_push_info.overflow = n_ovf;
    assign o_push_info.count    = ELEM_COUNT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_p_valid  <= 1'b0;
            r_sum_xx   <= '0;
            r_sum_yy   <= '0;
            r_sum_xy   <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else if (!w_hold) begin
            r_in_valid <= i_valid;
            r_p_valid  <= r_in_valid;
            if (r_p_valid) begin
                if (r_p_last) begin
                    r_sum_xx <= '0;
                    r_sum_yy <= '0;
                    r_sum_xy <= '0;
                    r_count  <= '0;
                    r_ovf    <= 1'b0;
                end else begin
                    r_sum_xx <= n_sum_xx;
                    r_sum_yy <= n_sum_yy;
                    r_sum_xy <= n_sum_xy;
                    r_count  <= n_count;
                    r_ovf    <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            r_in_x    <= i_first_value;
            r_in_y    <= i_second_value;
            r_in_last <= i_last_element;
            r_p_last  <= r_in_last;
            r_p_xx    <= r_in_x * r_in_x;
            r_p_yy    <= r_in_y * r_in_y;
            r_p_xy    <= r_in_x * r_in_y;
        end
    end

endmodule

/* rtl/tsu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanimoto similarity result queue
// Short first-in first-out buffer of finished sums between front and back.
// ----------------------------------------------------------------------------
module tsu_queue import tsu_pkg::*; #(
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    output logic              o_pop_valid,
    output logic [DATA_W-1:0] o_pop_data,
    input  logic              i_pop
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full      = r_count == CNT_W'(Q_DEPTH);
    assign o_pop_valid = r_count != '0;
    assign o_pop_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/tsu_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tanimoto similarity back end
// Forms the denominator and runs a restoring divider to a rounded Q2.14 result.
// ----------------------------------------------------------------------------
`include "tanimoto_similarity_unit_macros.svh"

module tsu_divider import tsu_pkg::*; #(
    parameter int SUM_W = sum_width(DEF_VALUE_BITS, DEF_MAX_LENGTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop_valid,
    output logic                    o_pop,
    input  logic [SUM_W-1:0]        i_xy,
    input  logic [SUM_W-1:0]        i_xx,
    input  logic [SUM_W-1:0]        i_yy,
    input  t_tail_info              i_info,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SIM_W-1:0] o_similarity,
    output logic                    o_zero_denominator,
    output logic                    o_length_overflow,
    output logic [ELEM_COUNT_W-1:0] o_element_count
);

    localparam int STEP_W = $clog2(FRAC_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEN,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [SUM_W-1:0]        r_xy;
    logic [SUM_W-1:0]        r_xx;
    logic [SUM_W-1:0]        r_yy;
    t_tail_info              r_info;
    logic [SUM_W-1:0]        r_den;
    logic [SUM_W-1:0]        r_rem;
    logic                    r_neg;
    logic                    r_zd;
    logic                    r_sat;
    logic [FRAC_STEPS-1:0]   r_frac;
    logic [STEP_W-1:0]       r_step;
    logic                    r_o_valid;
    logic signed [SIM_W-1:0] r_o_sim;
    logic                    r_o_zd;
    logic                    r_o_ovf;
    logic [ELEM_COUNT_W-1:0] r_o_count;

    logic                    w_out_free;
    logic [SUM_W-1:0]        w_den;
    logic [SUM_W-1:0]        w_mag;
    logic [SUM_W-1:0]        w_shift;
    logic                    w_ge;
    logic [SIM_W-1:0]        w_round;
    logic [SIM_W-1:0]        w_q;
    logic [SIM_W-1:0]        w_q_sat;
    logic [SIM_W-1:0]        w_sim;

    assign w_out_free = ~r_o_valid | ~i_stall;
    assign o_pop      = (r_state == S_IDLE) & i_pop_valid;

    assign w_den   = r_xx + r_yy - r_xy;
    assign w_mag   = r_xy[SUM_W-1] ? SUM_W'(0) - r_xy : r_xy;
    assign w_shift = {r_rem[SUM_W-2:0], 1'b0};
    assign w_ge    = w_shift >= r_den;
    assign w_round = SIM_W'(r_frac) + SIM_W'(1);
    assign w_q     = w_round >> 1;
    assign w_q_sat = (r_sat || (w_q > ONE_Q14)) ? ONE_Q14 : w_q;
    assign w_sim   = r_zd ? '0 : (r_neg ? SIM_W'(0) - w_q_sat : w_q_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_xy    <= i_xy;
                        r_xx    <= i_xx;
                        r_yy    <= i_yy;
                        r_info  <= i_info;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den   <= w_den;
                    r_rem   <= w_mag;
                    r_neg   <= r_xy[SUM_W-1];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_zd   <= (r_den == '0) | r_den[SUM_W-1];
                    r_sat  <= r_rem >= r_den;
                    r_frac <= '0;
                    r_step <= '0;
                    if ((r_den == '0) || r_den[SUM_W-1] || (r_rem >= r_den)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_shift - r_den : w_shift;
                    r_frac <= {r_frac[FRAC_STEPS-2:0], w_ge};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(FRAC_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_sim   <= w_sim;
                        r_o_zd    <= r_zd;
                        r_o_ovf   <= r_info.overflow;
                        r_o_count <= r_info.count;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_similarity       = r_o_sim;
    assign o_zero_denominator = r_o_zd;
    assign o_length_overflow  = r_o_ovf;
    assign o_element_count    = r_o_count;

    `TSU_ASSERT_IMPL(a_rem_below_den, r_state == S_DIV, r_rem < r_den)
    `TSU_ASSERT_IMPL(a_zero_den_gives_zero, r_o_valid && r_o_zd, r_o_sim == '0)
    `TSU_ASSERT_NEXT(a_out_loads, r_state == S_OUT && w_out_free, r_o_valid && r_state == S_IDLE)
    `TSU_ASSERT_IMPL(a_sim_in_range, r_o_valid, r_o_sim <= $signed(ONE_Q14) && r_o_sim >= -$signed(ONE_Q14))

endmodule
